// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the frame builder modules.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// A condition that must hold at every clock edge outside reset.
`define TFB_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("frame builder check failed");
// A condition that must hold in the cycle after its trigger.
`define TFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame builder check failed");
`else
`define TFB_ASSERT(lbl, clk, rst_n, expr)
`define TFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/tfb_pkg.sv =====
// Package of the telecontrol frame builder: request codes, frame constants
// and the frame descriptor type. No dependencies.
`timescale 1ns / 1ps

package tfb_pkg;

    // Number of stations that keep a frame count bit.
    localparam int STATIONS = 16;

    // Largest link user data length (control field through last ASDU byte).
    localparam int BODY_MAX = 15;

    // Frames buffered between the request decoder and the serializer.
    localparam int QUEUE_DEPTH = 2;

    // Request codes.
    localparam logic [3:0] REQ_LINK_STAT = 4'd0;
    localparam logic [3:0] REQ_RESET     = 4'd1;
    localparam logic [3:0] REQ_CLASS1    = 4'd2;
    localparam logic [3:0] REQ_CLASS2    = 4'd3;
    localparam logic [3:0] REQ_GI        = 4'd4;
    localparam logic [3:0] REQ_COUNTER   = 4'd5;
    localparam logic [3:0] REQ_CLOCK     = 4'd6;
    localparam logic [3:0] REQ_DOUBLE    = 4'd7;
    localparam logic [3:0] REQ_STEP      = 4'd8;
    localparam logic [3:0] REQ_SP_NORM   = 4'd9;
    localparam logic [3:0] REQ_SP_SCALED = 4'd10;
    localparam logic [3:0] REQ_PARAM     = 4'd11;
    localparam logic [3:0] REQ_EXECUTE   = 4'd12;

    // Frame delimiters.
    localparam logic [7:0] FT_FIXED_START = 8'h10;
    localparam logic [7:0] FT_VAR_START   = 8'h68;
    localparam logic [7:0] FT_END         = 8'h16;

    // Control field codes.
    localparam logic [7:0] CTRL_LINK_STAT = 8'h49;
    localparam logic [7:0] CTRL_RESET     = 8'h40;
    localparam logic [7:0] CTRL_CLASS1    = 8'h5A;
    localparam logic [7:0] CTRL_CLASS2    = 8'h5B;
    localparam logic [7:0] CTRL_USER      = 8'h53;
    localparam logic [7:0] CTRL_BCAST     = 8'h44;
    localparam logic [7:0] FCB_BIT        = 8'h20;
    localparam logic [7:0] ADDR_BCAST     = 8'hFF;

    // ASDU header codes.
    localparam logic [7:0] VSQ_ONE     = 8'h01;
    localparam logic [7:0] VSQ_GI      = 8'h81;
    localparam logic [7:0] COT_ACT     = 8'h06;
    localparam logic [7:0] QOI_STATION = 8'd20;
    localparam logic [7:0] QCC_GENERAL = 8'h41;
    localparam logic [7:0] QUAL_MASK   = 8'h3F;

    // Type identifiers.
    localparam logic [7:0] TI_GI        = 8'd100;
    localparam logic [7:0] TI_COUNTER   = 8'd101;
    localparam logic [7:0] TI_CLOCK     = 8'd103;
    localparam logic [7:0] TI_DOUBLE    = 8'd46;
    localparam logic [7:0] TI_STEP      = 8'd47;
    localparam logic [7:0] TI_SP_NORM   = 8'd48;
    localparam logic [7:0] TI_SP_SCALED = 8'd49;
    localparam logic [7:0] TI_PARAM     = 8'd110;

    // Link user data lengths.
    localparam logic [3:0] LEN_FIXED = 4'd2;
    localparam logic [3:0] LEN_SHORT = 4'd9;
    localparam logic [3:0] LEN_LONG  = 4'd11;
    localparam logic [3:0] LEN_CLOCK = 4'd15;

    // One frame as handed from the decoder to the serializer. For a fixed
    // frame the body holds the control and address bytes.
    typedef struct packed {
        logic                     is_var;
        logic [3:0]               len;
        logic [BODY_MAX-1:0][7:0] body;
    } t_frame;

endpackage

// ===== hdl/telecontrol_master_frame_builder.sv =====
// A taken request is registered in the queue; its first byte then goes through the output register.
// One byte per cycle while pop is held; a frame is 5, 15, 17 or 21 bytes, set by the decoder.
// A request is taken every cycle until the two-frame queue fills; then as the serializer frees one.
// Reset is synchronous, active low: clears config, frame count bits, command flag, queue, serializer.
// The stored command payload is not reset; execute before any stored command sends no frame.
`timescale 1ns / 1ps

module telecontrol_master_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [3:0]  i_req_type,
    input  logic [3:0]  i_station,
    input  logic [7:0]  i_target_station,
    input  logic [15:0] i_info_address,
    input  logic [15:0] i_value,
    input  logic [6:0]  i_qualifier,
    input  logic        i_select,
    input  logic [29:0] i_date_time,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_frame_byte,
    output logic        o_last
);

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_valid;
    tfb_pkg::t_frame q_in;
    tfb_pkg::t_frame q_out;

    assign full = q_full;

    // Request decoder.
    tfb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_push           (push),
        .i_req_type       (i_req_type),
        .i_station        (i_station),
        .i_target_station (i_target_station),
        .i_info_address   (i_info_address),
        .i_value          (i_value),
        .i_qualifier      (i_qualifier),
        .i_select         (i_select),
        .i_date_time      (i_date_time),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_q_frame        (q_in)
    );

    // Frame queue.
    tfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_frame (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_frame (q_out)
    );

    // Byte serializer.
    tfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_frame    (q_out),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_frame_byte (o_frame_byte),
        .o_last       (o_last)
    );

endmodule

// ===== hdl/tfb_front.sv =====
// Request decoder of the frame builder: keeps the frame count bits and the
// stored command, and turns requests into frame descriptors. Uses tfb_pkg.
`timescale 1ns / 1ps

module tfb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_push,
    input  logic [3:0]           i_req_type,
    input  logic [3:0]           i_station,
    input  logic [7:0]           i_target_station,
    input  logic [15:0]          i_info_address,
    input  logic [15:0]          i_value,
    input  logic [6:0]           i_qualifier,
    input  logic                 i_select,
    input  logic [29:0]          i_date_time,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output tfb_pkg::t_frame      o_q_frame
);

    // Configuration and per-station frame count bits.
    logic                         r_bcast;
    logic [tfb_pkg::STATIONS-1:0] r_fcb;

    // Stored command; only the valid flag is reset, the payload is not.
    logic        r_cmd_valid;
    logic [7:0]  r_cmd_addr;
    logic [7:0]  r_cmd_type;
    logic [15:0] r_cmd_ioa;
    logic [15:0] r_cmd_val;
    logic [7:0]  r_cmd_qual;
    logic        r_cmd_long;

    logic [7:0]  n_cmd_addr;
    logic [7:0]  n_cmd_type;
    logic [7:0]  n_cmd_qual;
    logic        n_cmd_long;

    logic            accept;
    logic            st_ok;
    logic            fcb_now;
    logic            fcb_tog;
    logic [7:0]      st8;
    logic [7:0]      ctrl_user;
    logic            has_frame;
    logic            toggle;
    logic            store;
    tfb_pkg::t_frame frame;

    // Fills the six-byte head: control, address, type, VSQ, cause, common address.
    function automatic tfb_pkg::t_frame set_head(input logic [7:0] ctrl,
                                                 input logic [7:0] addr,
                                                 input logic [7:0] ti,
                                                 input logic [7:0] vsq,
                                                 input logic [3:0] len);
        tfb_pkg::t_frame f;
        f         = '0;
        f.is_var  = 1'b1;
        f.len     = len;
        f.body[0] = ctrl;
        f.body[1] = addr;
        f.body[2] = ti;
        f.body[3] = vsq;
        f.body[4] = tfb_pkg::COT_ACT;
        f.body[5] = addr;
        return f;
    endfunction

    // Fixed frame: control and address only.
    function automatic tfb_pkg::t_frame set_fixed(input logic [7:0] ctrl,
                                                  input logic [7:0] addr);
        tfb_pkg::t_frame f;
        f         = '0;
        f.len     = tfb_pkg::LEN_FIXED;
        f.body[0] = ctrl;
        f.body[1] = addr;
        return f;
    endfunction

    assign accept    = i_push && !i_q_full;
    assign st_ok     = (32'(i_station) < tfb_pkg::STATIONS);
    assign fcb_now   = st_ok && r_fcb[i_station];
    assign fcb_tog   = st_ok && !r_fcb[i_station];
    assign st8       = {4'd0, i_station};
    assign ctrl_user = tfb_pkg::CTRL_USER | (fcb_tog ? tfb_pkg::FCB_BIT : 8'h00);

    // Decode the request into a frame and its side effects.
    always_comb begin
        frame      = '0;
        has_frame  = 1'b0;
        toggle     = 1'b0;
        store      = 1'b0;
        n_cmd_addr = r_cmd_addr;
        n_cmd_type = r_cmd_type;
        n_cmd_qual = r_cmd_qual;
        n_cmd_long = r_cmd_long;
        case (i_req_type)
            tfb_pkg::REQ_LINK_STAT: begin
                has_frame = 1'b1;
                frame = set_fixed(tfb_pkg::CTRL_LINK_STAT |
                                  (fcb_now ? tfb_pkg::FCB_BIT : 8'h00), st8);
            end
            tfb_pkg::REQ_RESET: begin
                has_frame = 1'b1;
                frame = set_fixed(tfb_pkg::CTRL_RESET, st8);
            end
            tfb_pkg::REQ_CLASS1, tfb_pkg::REQ_CLASS2: begin
                has_frame = 1'b1;
                toggle    = 1'b1;
                frame = set_fixed(((i_req_type == tfb_pkg::REQ_CLASS1) ?
                                   tfb_pkg::CTRL_CLASS1 : tfb_pkg::CTRL_CLASS2) |
                                  (fcb_tog ? tfb_pkg::FCB_BIT : 8'h00), st8);
            end
            tfb_pkg::REQ_GI: begin
                has_frame = 1'b1;
                toggle    = 1'b1;
                frame = set_head(ctrl_user, st8, tfb_pkg::TI_GI, tfb_pkg::VSQ_GI,
                                 tfb_pkg::LEN_SHORT);
                frame.body[8] = tfb_pkg::QOI_STATION;
            end
            tfb_pkg::REQ_COUNTER: begin
                has_frame = 1'b1;
                toggle    = 1'b1;
                frame = set_head(ctrl_user, st8, tfb_pkg::TI_COUNTER,
                                 tfb_pkg::VSQ_ONE, tfb_pkg::LEN_SHORT);
                frame.body[8] = tfb_pkg::QCC_GENERAL;
            end
            tfb_pkg::REQ_CLOCK: begin
                has_frame = 1'b1;
                if (r_bcast) begin
                    frame = set_head(tfb_pkg::CTRL_BCAST, tfb_pkg::ADDR_BCAST,
                                     tfb_pkg::TI_CLOCK, tfb_pkg::VSQ_ONE,
                                     tfb_pkg::LEN_CLOCK);
                end else begin
                    toggle = 1'b1;
                    frame = set_head(ctrl_user, st8, tfb_pkg::TI_CLOCK,
                                     tfb_pkg::VSQ_ONE, tfb_pkg::LEN_CLOCK);
                end
                frame.body[8]  = i_value[7:0];
                frame.body[9]  = i_value[15:8];
                frame.body[10] = {2'b00, i_date_time[5:0]};
                frame.body[11] = {3'b000, i_date_time[10:6]};
                frame.body[12] = {i_date_time[18:16], i_date_time[15:11]};
                frame.body[13] = {4'b0000, i_date_time[22:19]};
                frame.body[14] = {1'b0, i_date_time[29:23]};
            end
            tfb_pkg::REQ_DOUBLE, tfb_pkg::REQ_STEP: begin
                has_frame  = 1'b1;
                toggle     = 1'b1;
                store      = 1'b1;
                n_cmd_addr = i_target_station;
                n_cmd_type = (i_req_type == tfb_pkg::REQ_DOUBLE) ?
                             tfb_pkg::TI_DOUBLE : tfb_pkg::TI_STEP;
                n_cmd_qual = {i_select, i_qualifier};
                n_cmd_long = 1'b0;
                frame = set_head(ctrl_user, i_target_station, n_cmd_type,
                                 tfb_pkg::VSQ_ONE, tfb_pkg::LEN_SHORT);
                frame.body[6] = i_info_address[7:0];
                frame.body[7] = i_info_address[15:8];
                frame.body[8] = n_cmd_qual;
            end
            tfb_pkg::REQ_SP_NORM, tfb_pkg::REQ_SP_SCALED, tfb_pkg::REQ_PARAM: begin
                has_frame  = 1'b1;
                toggle     = 1'b1;
                store      = 1'b1;
                n_cmd_addr = st8;
                n_cmd_long = 1'b1;
                if (i_req_type == tfb_pkg::REQ_PARAM) begin
                    n_cmd_type = tfb_pkg::TI_PARAM;
                    n_cmd_qual = {1'b0, i_qualifier};
                end else begin
                    n_cmd_type = (i_req_type == tfb_pkg::REQ_SP_NORM) ?
                                 tfb_pkg::TI_SP_NORM : tfb_pkg::TI_SP_SCALED;
                    n_cmd_qual = {i_select, 7'd0};
                end
                frame = set_head(ctrl_user, st8, n_cmd_type, tfb_pkg::VSQ_ONE,
                                 tfb_pkg::LEN_LONG);
                frame.body[6]  = i_info_address[7:0];
                frame.body[7]  = i_info_address[15:8];
                frame.body[8]  = i_value[7:0];
                frame.body[9]  = i_value[15:8];
                frame.body[10] = n_cmd_qual;
            end
            tfb_pkg::REQ_EXECUTE: begin
                // Re-send the stored command with the top two qualifier bits, select among them, cleared.
                if (r_cmd_valid) begin
                    has_frame = 1'b1;
                    toggle    = 1'b1;
                    frame = set_head(ctrl_user, r_cmd_addr, r_cmd_type,
                                     tfb_pkg::VSQ_ONE,
                                     r_cmd_long ? tfb_pkg::LEN_LONG :
                                                  tfb_pkg::LEN_SHORT);
                    frame.body[6] = r_cmd_ioa[7:0];
                    frame.body[7] = r_cmd_ioa[15:8];
                    if (r_cmd_long) begin
                        frame.body[8]  = r_cmd_val[7:0];
                        frame.body[9]  = r_cmd_val[15:8];
                        frame.body[10] = r_cmd_qual & tfb_pkg::QUAL_MASK;
                    end else begin
                        frame.body[8] = r_cmd_qual & tfb_pkg::QUAL_MASK;
                    end
                end
            end
            default: begin
                has_frame = 1'b0;
            end
        endcase
    end

    assign o_q_push  = accept && has_frame;
    assign o_q_frame = frame;

    // Configuration, frame count bits and the stored command valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcast     <= 1'b0;
            r_fcb       <= '0;
            r_cmd_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bcast <= i_cfg_wdata;
            end
            if (accept && toggle && st_ok) begin
                r_fcb[i_station] <= !r_fcb[i_station];
            end
            if (accept && store) begin
                r_cmd_valid <= 1'b1;
            end
        end
    end

    // Stored command payload.
    always_ff @(posedge i_clk) begin
        if (accept && store) begin
            r_cmd_addr <= n_cmd_addr;
            r_cmd_type <= n_cmd_type;
            r_cmd_ioa  <= i_info_address;
            r_cmd_val  <= n_cmd_long ? i_value : 16'd0;
            r_cmd_qual <= n_cmd_qual;
            r_cmd_long <= n_cmd_long;
        end
    end

endmodule

// ===== hdl/tfb_queue.sv =====
// Short frame queue between the request decoder and the serializer.
// Uses tfb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tfb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tfb_pkg::t_frame i_frame,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output tfb_pkg::t_frame o_frame
);

    localparam int PTR_W = $clog2(tfb_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tfb_pkg::QUEUE_DEPTH + 1);

    tfb_pkg::t_frame r_mem [tfb_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(tfb_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd_ptr];

    // Wrap a pointer at the queue depth.
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (32'(p) == tfb_pkg::QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    `TFB_ASSERT(a_no_push_full, i_clk, i_rst_n, !(i_push && o_full && !i_pop))
    `TFB_ASSERT(a_no_pop_empty, i_clk, i_rst_n, !(i_pop && !o_valid))
    `TFB_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

// ===== hdl/tfb_back.sv =====
// Frame serializer: walks one frame descriptor a byte per cycle while the output is
// popped, adds the delimiters and the checksum, and holds the byte in an output register.
// Uses tfb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tfb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  tfb_pkg::t_frame i_q_frame,
    output logic            o_q_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [7:0]      o_frame_byte,
    output logic            o_last
);

    logic [4:0] r_pos;
    logic [7:0] r_sum;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [4:0] hdr_len;
    logic [4:0] body_end;
    logic [4:0] body_off;
    logic [7:0] byte_now;
    logic       last_now;
    logic       in_body;
    logic       advance;
    logic       out_take;

    assign hdr_len  = i_q_frame.is_var ? 5'd4 : 5'd1;
    assign body_end = hdr_len + {1'b0, i_q_frame.len};
    assign body_off = r_pos - hdr_len;

    // Pick the byte at the current position of the frame.
    always_comb begin
        byte_now = tfb_pkg::FT_END;
        last_now = 1'b0;
        in_body  = 1'b0;
        if (r_pos < hdr_len) begin
            if (!i_q_frame.is_var) begin
                byte_now = tfb_pkg::FT_FIXED_START;
            end else if (r_pos == 5'd0 || r_pos == 5'd3) begin
                byte_now = tfb_pkg::FT_VAR_START;
            end else begin
                byte_now = {4'd0, i_q_frame.len};
            end
        end else if (r_pos < body_end) begin
            in_body  = 1'b1;
            byte_now = i_q_frame.body[body_off[3:0]];
        end else if (r_pos == body_end) begin
            byte_now = r_sum;
        end else begin
            byte_now = tfb_pkg::FT_END;
            last_now = 1'b1;
        end
    end

    assign out_take = i_pop && r_out_valid;
    assign advance  = i_q_valid && (!r_out_valid || i_pop);
    assign o_q_pop  = advance && last_now;

    // Position and checksum within the frame, and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                if (last_now) begin
                    r_pos <= '0;
                    r_sum <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                    if (in_body) begin
                        r_sum <= r_sum + byte_now;
                    end
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= byte_now;
            r_out_last <= last_now;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last       = r_out_last;

    `TFB_ASSERT(a_last_is_end, i_clk, i_rst_n, !(r_out_valid && r_out_last) || (r_out_byte == tfb_pkg::FT_END))
    `TFB_ASSERT(a_idle_at_start, i_clk, i_rst_n, i_q_valid || (r_pos == 5'd0))
    `TFB_ASSERT(a_pos_bound, i_clk, i_rst_n, r_pos <= 5'd20)

endmodule
